// ===== design/mtrr_range_memory_type_lookup_core_macros.svh =====
// ----------------------------------------------------------------------------
// MTRR lookup assertion macros
// Shared assertion shorthands for the range lookup checker.
// ----------------------------------------------------------------------------
`ifndef MTRR_RANGE_MEMORY_TYPE_LOOKUP_CORE_MACROS_SVH
`define MTRR_RANGE_MEMORY_TYPE_LOOKUP_CORE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define MTRR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define MTRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define MTRR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mtrr_pkg.sv =====
// ----------------------------------------------------------------------------
// MTRR lookup package
// Field widths, command codes and the beat that moves along the cell chain.
// ----------------------------------------------------------------------------
package mtrr_pkg;

    localparam int IDX_W       = 4;
    localparam int PAGE_W      = 40;
    localparam int TYPE_W      = 3;
    localparam int LPN_W       = 31;
    localparam int PAGE_SHIFT  = 12;
    localparam int LARGE_SHIFT = 21;
    localparam int FULL_W      = PAGE_W + PAGE_SHIFT;   // 52-bit byte address

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // one beat in flight; typ is the entry type for a load and the running
    // result for a query
    typedef struct packed {
        logic              vld;
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic              act;
        logic [TYPE_W-1:0] typ;
        logic [LPN_W-1:0]  lpn;
    } t_beat;

endpackage

// ===== design/mtrr_prep.sv =====
// ----------------------------------------------------------------------------
// MTRR input stage
// Registers the accepted beat and turns a load's base/mask into 2 MB-granular
// low and high page bounds, with saturation at the top of the address space.
// ----------------------------------------------------------------------------
module mtrr_prep #(
    parameter int ADDRESS_BITS = 52
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  logic                                           i_valid,
    input  logic                                           i_cmd,
    input  logic [mtrr_pkg::IDX_W-1:0]                     i_entry_index,
    input  logic [mtrr_pkg::PAGE_W-1:0]                    i_base_page,
    input  logic [mtrr_pkg::PAGE_W-1:0]                    i_mask_page,
    input  logic [mtrr_pkg::TYPE_W-1:0]                    i_entry_type,
    input  logic                                           i_entry_enable,
    input  logic [mtrr_pkg::LPN_W-1:0]                     i_large_page_number,
    input  logic [mtrr_pkg::TYPE_W-1:0]                    i_default_type,
    output mtrr_pkg::t_beat                                o_beat,
    output logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  o_lo_lp,
    output logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  o_hi_lp
);
    import mtrr_pkg::*;

    localparam int LPW = ADDRESS_BITS - LARGE_SHIFT;

    t_beat               r_beat, n_beat;
    logic [LPW-1:0]      r_lo_lp, n_lo_lp;
    logic [LPW-1:0]      r_hi_lp, n_hi_lp;
    logic [FULL_W-1:0]   w_base_full;
    logic [ADDRESS_BITS-1:0] w_lo;
    logic [PAGE_W-1:0]   w_iso;
    logic [FULL_W:0]     w_sum;
    logic                w_sat;

    always_comb begin
        w_base_full = {i_base_page, {PAGE_SHIFT{1'b0}}};
        w_lo        = w_base_full[ADDRESS_BITS-1:0];
        // isolate lowest set mask bit: that is the range length in pages
        w_iso       = i_mask_page & (~i_mask_page + PAGE_W'(1));
        w_sum       = (FULL_W+1)'(w_lo) + {1'b0, w_iso, {PAGE_SHIFT{1'b0}}}
                      - (FULL_W+1)'(1);
        w_sat       = |w_sum[FULL_W:ADDRESS_BITS];

        n_lo_lp = w_lo[ADDRESS_BITS-1:LARGE_SHIFT];
        n_hi_lp = w_sat ? {LPW{1'b1}} : w_sum[ADDRESS_BITS-1:LARGE_SHIFT];

        n_beat.vld = i_valid;
        n_beat.cmd = t_cmd'(i_cmd);
        n_beat.idx = i_entry_index;
        n_beat.act = i_entry_enable && (|i_mask_page);
        n_beat.lpn = i_large_page_number;
        n_beat.typ = (t_cmd'(i_cmd) == CMD_QUERY) ? i_default_type : i_entry_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lo_lp <= n_lo_lp;
            r_hi_lp <= n_hi_lp;
        end
    end

    assign o_beat  = r_beat;
    assign o_lo_lp = r_lo_lp;
    assign o_hi_lp = r_hi_lp;

endmodule

// ===== design/mtrr_cell.sv =====
// ----------------------------------------------------------------------------
// MTRR range cell
// Holds one range entry. A load beat addressed to it rewrites the entry; a
// query beat that overlaps the active range takes the entry's type.
// ----------------------------------------------------------------------------
module mtrr_cell #(
    parameter int ADDRESS_BITS = 52,
    parameter int CELL_IDX     = 0
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_adv,
    input  mtrr_pkg::t_beat                                i_beat,
    input  logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  i_lo_lp,
    input  logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  i_hi_lp,
    output mtrr_pkg::t_beat                                o_beat,
    output logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  o_lo_lp,
    output logic [ADDRESS_BITS-mtrr_pkg::LARGE_SHIFT-1:0]  o_hi_lp
);
    import mtrr_pkg::*;

    localparam int LPW = ADDRESS_BITS - LARGE_SHIFT;

    // stored entry
    logic              r_act;
    logic [TYPE_W-1:0] r_typ;
    logic [LPW-1:0]    r_lo;
    logic [LPW-1:0]    r_hi;

    // forwarded beat
    t_beat             r_beat, n_beat;
    logic [LPW-1:0]    r_lo_q;
    logic [LPW-1:0]    r_hi_q;

    logic              w_sel;
    logic              w_hit;

    always_comb begin
        w_sel = i_beat.vld && (i_beat.cmd == CMD_LOAD)
                && (32'(i_beat.idx) == CELL_IDX);
        w_hit = r_act && (i_beat.lpn >= LPN_W'(r_lo)) && (i_beat.lpn <= LPN_W'(r_hi));
        n_beat = i_beat;
        if (i_beat.cmd == CMD_QUERY && w_hit) begin
            n_beat.typ = r_typ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_beat.vld <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
            if (w_sel) begin
                r_act <= i_beat.act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lo_q <= i_lo_lp;
            r_hi_q <= i_hi_lp;
            if (w_sel) begin
                r_typ <= i_beat.typ;
                r_lo  <= i_lo_lp;
                r_hi  <= i_hi_lp;
            end
        end
    end

    assign o_beat  = r_beat;
    assign o_lo_lp = r_lo_q;
    assign o_hi_lp = r_hi_q;

endmodule

// ===== design/mtrr_range_memory_type_lookup_core.sv =====
// ----------------------------------------------------------------------------
// MTRR range memory-type lookup core
// Variable memory-type range table with 2 MB large-page type lookup.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): a beat with i_cmd = load writes range entry
// i_entry_index from base/mask page numbers, type and enable; a beat with
// i_cmd = query asks for the memory type of 2 MB page i_large_page_number,
// falling back to i_default_type. Loads give no result; each query gives one
// beat on the output channel (o_valid/i_ready, o_memory_type).
// Every beat passes an input stage and then a chain of RANGE_COUNT cells, one
// cell per cycle while the chain is not held; cell k holds entry k and a later
// cell overrides an earlier one, so the highest matching entry wins. Loads ride
// the same chain, so each query sees exactly the loads accepted before it.
// Throughput: one beat per cycle unless the chain holds, loads and queries mixed.
// Reset clears every entry to disabled and empties the chain; no clearing
// pass is needed. While a result waits on a low i_ready the whole chain
// holds and o_ready drops; load beats leaving the chain never stall it.
// ----------------------------------------------------------------------------
module mtrr_range_memory_type_lookup_core #(
    parameter int RANGE_COUNT  = 16,
    parameter int ADDRESS_BITS = 52
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [mtrr_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [mtrr_pkg::PAGE_W-1:0]   i_base_page,
    input  logic [mtrr_pkg::PAGE_W-1:0]   i_mask_page,
    input  logic [mtrr_pkg::TYPE_W-1:0]   i_entry_type,
    input  logic                          i_entry_enable,
    input  logic [mtrr_pkg::LPN_W-1:0]    i_large_page_number,
    input  logic [mtrr_pkg::TYPE_W-1:0]   i_default_type,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mtrr_pkg::TYPE_W-1:0]   o_memory_type
);
    import mtrr_pkg::*;

    localparam int LPW = ADDRESS_BITS - LARGE_SHIFT;

    t_beat          w_beat [0:RANGE_COUNT];
    logic [LPW-1:0] w_lo   [0:RANGE_COUNT];
    logic [LPW-1:0] w_hi   [0:RANGE_COUNT];
    logic           w_adv;
    logic           w_out_vld;

    assign w_out_vld = w_beat[RANGE_COUNT].vld && (w_beat[RANGE_COUNT].cmd == CMD_QUERY);
    assign w_adv     = !w_out_vld || i_ready;

    mtrr_prep #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_prep (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_adv               (w_adv),
        .i_valid             (i_valid),
        .i_cmd               (i_cmd),
        .i_entry_index       (i_entry_index),
        .i_base_page         (i_base_page),
        .i_mask_page         (i_mask_page),
        .i_entry_type        (i_entry_type),
        .i_entry_enable      (i_entry_enable),
        .i_large_page_number (i_large_page_number),
        .i_default_type      (i_default_type),
        .o_beat              (w_beat[0]),
        .o_lo_lp             (w_lo[0]),
        .o_hi_lp             (w_hi[0])
    );

    for (genvar g = 0; g < RANGE_COUNT; g++) begin : g_cell
        mtrr_cell #(
            .ADDRESS_BITS (ADDRESS_BITS),
            .CELL_IDX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_beat  (w_beat[g]),
            .i_lo_lp (w_lo[g]),
            .i_hi_lp (w_hi[g]),
            .o_beat  (w_beat[g+1]),
            .o_lo_lp (w_lo[g+1]),
            .o_hi_lp (w_hi[g+1])
        );
    end

    assign o_ready       = w_adv;
    assign o_valid       = w_out_vld;
    assign o_memory_type = w_beat[RANGE_COUNT].typ;

endmodule

// ===== design/mtrr_chk.sv =====
// ----------------------------------------------------------------------------
// MTRR lookup port checker
// Watches the top level's handshakes and flow control over time.
// ----------------------------------------------------------------------------
`include "mtrr_range_memory_type_lookup_core_macros.svh"

module mtrr_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [mtrr_pkg::TYPE_W-1:0] i_out_type
);

    // chain is empty right after reset
    `MTRR_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result after reset")

    // a stalled result holds
    `MTRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_type), "stalled result changed")

    // a waiting result freezes the input side
    `MTRR_ASSERT_SAME(a_stall_in, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "input taken while output stalled")

    // nothing waiting: input must be open
    `MTRR_ASSERT_SAME(a_open_in, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with no result pending")

endmodule

bind mtrr_range_memory_type_lookup_core mtrr_chk u_mtrr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_type  (o_memory_type)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// MTRR range memory-type lookup testbench
// Loads range entries and queries 2 MB pages through the valid/ready input,
// predicts each query's memory type from a local copy of the range table,
// and checks every result beat in order against the predicted types.
// ----------------------------------------------------------------------------
module tb;
    import mtrr_pkg::*;

    localparam int  RANGE_COUNT  = 16;
    localparam int  ADDRESS_BITS = 52;
    localparam int  LATENCY      = RANGE_COUNT + 1;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_ITEMS = 500;
    localparam logic [63:0] ADDR_MAX = (64'd1 << ADDRESS_BITS) - 64'd1;

    typedef struct {
        t_cmd              cmd;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] mask;
        logic [TYPE_W-1:0] typ;
        logic              en;
        logic [LPN_W-1:0]  lpn;
        logic [TYPE_W-1:0] dflt;
    } t_lookup_req;

    logic                i_clk               = 1'b0;
    logic                i_rst_n             = 1'b0;
    logic                i_valid             = 1'b0;
    logic                i_cmd               = 1'b0;
    logic [IDX_W-1:0]    i_entry_index       = '0;
    logic [PAGE_W-1:0]   i_base_page         = '0;
    logic [PAGE_W-1:0]   i_mask_page         = '0;
    logic [TYPE_W-1:0]   i_entry_type        = '0;
    logic                i_entry_enable      = 1'b0;
    logic [LPN_W-1:0]    i_large_page_number = '0;
    logic [TYPE_W-1:0]   i_default_type      = '0;
    logic                i_ready             = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [TYPE_W-1:0]   o_memory_type;

    mtrr_range_memory_type_lookup_core #(
        .RANGE_COUNT  (RANGE_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_cmd               (i_cmd),
        .i_entry_index       (i_entry_index),
        .i_base_page         (i_base_page),
        .i_mask_page         (i_mask_page),
        .i_entry_type        (i_entry_type),
        .i_entry_enable      (i_entry_enable),
        .i_large_page_number (i_large_page_number),
        .i_default_type      (i_default_type),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_memory_type       (o_memory_type)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // range table shadow and type prediction
    // ------------------------------------------------------------------
    logic [63:0]       range_lo   [RANGE_COUNT];
    logic [63:0]       range_hi   [RANGE_COUNT];
    logic [TYPE_W-1:0] range_typ  [RANGE_COUNT];
    logic              range_on   [RANGE_COUNT];

    t_lookup_req       pending_q[$];
    logic [TYPE_W-1:0] exp_memory_type_q[$];

    int err_cnt      = 0;
    int loads_sent   = 0;
    int queries_sent = 0;
    int range_hits   = 0;
    int types_seen   = 0;
    int in_stalls    = 0;
    int cycle_cnt    = 0;

    initial begin
        for (int i = 0; i < RANGE_COUNT; i++) begin
            range_lo[i]  = '0;
            range_hi[i]  = '0;
            range_typ[i] = '0;
            range_on[i]  = 1'b0;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    task automatic write_range_entry(input t_lookup_req r);
        logic [63:0] lo;
        logic [63:0] hi;
        int          lsb;
        if (r.idx >= RANGE_COUNT)
            return;
        range_typ[r.idx] = r.typ;
        if (!r.en || r.mask == '0) begin
            range_on[r.idx] = 1'b0;
            range_lo[r.idx] = '0;
            range_hi[r.idx] = '0;
            return;
        end
        lsb = PAGE_W;
        for (int b = PAGE_W - 1; b >= 0; b--)
            if (r.mask[b])
                lsb = b;
        lo = (64'(r.base) << PAGE_SHIFT) & ADDR_MAX;
        hi = lo + (64'd1 << (lsb + PAGE_SHIFT)) - 64'd1;
        if (hi > ADDR_MAX)
            hi = ADDR_MAX;   // end saturates at top of address space
        range_lo[r.idx] = lo;
        range_hi[r.idx] = hi;
        range_on[r.idx] = 1'b1;
    endtask

    function automatic logic [TYPE_W-1:0] predict_memory_type(input t_lookup_req r,
                                                              output bit hit);
        logic [63:0]       first;
        logic [63:0]       last;
        logic [TYPE_W-1:0] res;
        first = 64'(r.lpn) << LARGE_SHIFT;
        last  = first + (64'd1 << LARGE_SHIFT) - 64'd1;
        res   = r.dflt;
        hit   = 1'b0;
        // ascending scan: highest matching index wins
        for (int i = 0; i < RANGE_COUNT; i++)
            if (range_on[i] && last >= range_lo[i] && first <= range_hi[i]) begin
                res = range_typ[i];
                hit = 1'b1;
            end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0] aim_base [RANGE_COUNT];
    logic [PAGE_W-1:0] region   [4];

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_load(input logic [IDX_W-1:0] idx, input logic [PAGE_W-1:0] base,
                            input logic [PAGE_W-1:0] mask, input logic [TYPE_W-1:0] typ,
                            input logic en);
        t_lookup_req r;
        r.cmd  = CMD_LOAD;
        r.idx  = idx;
        r.base = base;
        r.mask = mask;
        r.typ  = typ;
        r.en   = en;
        r.lpn  = LPN_W'($urandom());    // unused by a load
        r.dflt = TYPE_W'($urandom());
        aim_base[idx] = base;
        pending_q.push_back(r);
    endtask

    task automatic add_query(input logic [LPN_W-1:0] lpn, input logic [TYPE_W-1:0] dflt);
        t_lookup_req r;
        r.cmd  = CMD_QUERY;
        r.idx  = IDX_W'($urandom());    // load fields unused by a query
        r.base = PAGE_W'(rand64());
        r.mask = PAGE_W'(rand64());
        r.typ  = TYPE_W'($urandom());
        r.en   = 1'($urandom());
        r.lpn  = lpn;
        r.dflt = dflt;
        pending_q.push_back(r);
    endtask

    task automatic add_random_load();
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] mask;
        int                lsb;
        int                sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            base = region[$urandom_range(0, 3)] + PAGE_W'($urandom_range(0, 8191));
        else if (sel < 85)
            base = PAGE_W'(rand64());
        else
            base = {PAGE_W{1'b1}} - PAGE_W'($urandom_range(0, 1023));
        lsb = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 14) : $urandom_range(0, 39);
        mask = PAGE_W'(rand64()) | (PAGE_W'(1) << lsb);
        mask = mask & ~((PAGE_W'(1) << lsb) - PAGE_W'(1));
        if ($urandom_range(0, 19) == 0)
            mask = '0;
        add_load(IDX_W'($urandom()), base, mask, TYPE_W'($urandom()),
                 $urandom_range(0, 99) < 85);
    endtask

    task automatic add_random_query();
        logic [LPN_W-1:0] lpn;
        int               sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)   // aim at or next to a loaded range
            lpn = LPN_W'(aim_base[$urandom_range(0, RANGE_COUNT - 1)] >> 9)
                  + LPN_W'($urandom_range(0, 2)) - LPN_W'(1);
        else if (sel < 85)
            lpn = LPN_W'($urandom());
        else if (sel < 93)
            lpn = LPN_W'($urandom_range(0, 3));
        else
            lpn = {LPN_W{1'b1}} - LPN_W'($urandom_range(0, 3));
        add_query(lpn, TYPE_W'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of beats separated by random gaps
    // ------------------------------------------------------------------
    t_lookup_req cur_req;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(posedge i_clk) begin
        bit hit;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_ready)
                in_stalls++;
            if (i_valid && o_ready) begin
                if (cur_req.cmd == CMD_LOAD) begin
                    write_range_entry(cur_req);
                    loads_sent++;
                end else begin
                    exp_memory_type_q.push_back(predict_memory_type(cur_req, hit));
                    if (hit)
                        range_hits++;
                    queries_sent++;
                end
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    cur_req = pending_q.pop_front();
                    i_valid             <= 1'b1;
                    i_cmd               <= cur_req.cmd;
                    i_entry_index       <= cur_req.idx;
                    i_base_page         <= cur_req.base;
                    i_mask_page         <= cur_req.mask;
                    i_entry_type        <= cur_req.typ;
                    i_entry_enable      <= cur_req.en;
                    i_large_page_number <= cur_req.lpn;
                    i_default_type      <= cur_req.dflt;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: rotating stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    logic [15:0] rdy_pat    = 16'hFFFF;
    int          pat_pos    = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    int          rx_seen    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                rx_seen++;
            if (pat_pos == 63) begin
                case ($urandom_range(0, 3))
                    0: rdy_pat = 16'hFFFF;
                    1: rdy_pat = 16'($urandom());
                    2: rdy_pat = 16'($urandom()) | 16'($urandom());
                    default: rdy_pat = 16'($urandom()) & 16'($urandom());
                endcase
            end
            pat_pos = (pat_pos + 1) % 64;
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && rx_seen >= 80) begin
                // long hold so the chain fills and the input stalls
                hold_done = 1'b1;
                hold_left = 200;
                i_ready <= 1'b0;
            end else begin
                i_ready <= rdy_pat[pat_pos % 16];
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    logic [TYPE_W-1:0] want_type;
    bit [7:0]          type_mask = '0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            type_mask[o_memory_type] = 1'b1;
            if (exp_memory_type_q.size() == 0) begin
                report_error($sformatf("unexpected result beat, memory_type=%0d",
                                       o_memory_type));
            end else begin
                want_type = exp_memory_type_q.pop_front();
                if (o_memory_type !== want_type)
                    report_error($sformatf("memory_type got %0d want %0d",
                                           o_memory_type, want_type));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        region[0] = '0;
        region[1] = PAGE_W'(rand64()) & ~PAGE_W'(8191);
        region[2] = PAGE_W'(rand64()) & ~PAGE_W'(8191);
        region[3] = {PAGE_W{1'b1}} - PAGE_W'(16383);
        for (int i = 0; i < RANGE_COUNT; i++)
            aim_base[i] = region[i % 4];

        // directed: empty table, small and huge ranges, priority, disable,
        // zero mask, saturated end, top and bottom of the page space
        add_query('0, 3'd5);
        add_load(4'd0, '0, 40'h1, 3'd6, 1'b1);
        add_query('0, 3'd0);
        add_query(31'd1, 3'd3);
        add_load(4'd15, 40'h200, 40'h200, 3'd1, 1'b1);
        add_query(31'd1, 3'd7);
        add_load(4'd3, '0, 40'h80_0000_0000, 3'd2, 1'b1);
        add_query('0, 3'd0);
        add_query(31'h3FFF_FFFF, 3'd4);
        add_query(31'h4000_0000, 3'd4);
        add_load(4'd14, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 3'd7, 1'b1);
        add_query(31'h7FFF_FFFF, 3'd0);
        add_load(4'd13, 40'hFF_FFFF_F000, 40'h80_0000_0000, 3'd4, 1'b1);
        add_query(31'h7FFF_FFFF, 3'd0);
        add_query(31'h7FFF_FFF0, 3'd1);
        add_load(4'd14, 40'hFF_FFFF_FFFF, 40'h1, 3'd3, 1'b0);
        add_query(31'h7FFF_FFFF, 3'd0);
        add_load(4'd13, 40'hFF_FFFF_F000, '0, 3'd5, 1'b1);
        add_query(31'h7FFF_FFFF, 3'd2);
        add_load(4'd0, '0, 40'h1, 3'd0, 1'b0);
        add_query('0, 3'd6);
        add_query(31'd1, 3'd6);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            if ($urandom_range(0, 99) < 35)
                add_random_load();
            else
                add_random_query();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid || exp_memory_type_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        if (exp_memory_type_q.size() != 0)
            report_error($sformatf("%0d results never arrived", exp_memory_type_q.size()));
        for (int t = 0; t < 8; t++)
            types_seen += type_mask[t];

        $display("%0d loads and %0d queries, %0d queries overlapped an active range",
                 loads_sent, queries_sent, range_hits);
        $display("%0d of 8 memory types returned, %0d input stall cycles, %0d mismatches",
                 types_seen, in_stalls, err_cnt);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mtrr_pkg.sv
design/mtrr_prep.sv
design/mtrr_cell.sv
design/mtrr_range_memory_type_lookup_core.sv
design/mtrr_chk.sv
tb/tb.sv
